[design/hcbf_pkg.sv]
// ----------------------------------------------------------------------------
// hcbf_pkg
// shared types and constants of the chunked body framer: word formats,
// register map and field widths
// ----------------------------------------------------------------------------
package hcbf_pkg;

    localparam int MAX_HEX_DIGITS_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 2;
    localparam int ERR_W   = 2;
    localparam int TOTAL_W = 48;
    localparam int LIMIT_W = 5;
    localparam int LINE_W  = 5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(18);
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(3);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(18);

    localparam logic [APB_ADDR_W-1:0] REG_SIZE_LINE_LIMIT = APB_ADDR_W'(0);

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              start_req;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [ROLE_W-1:0]  byte_role;
        logic               message_done;
        logic [ERR_W-1:0]   error_code;
        logic [TOTAL_W-1:0] total_bytes;
    } out_t;

endpackage

[design/hcbf_core.sv]
// ----------------------------------------------------------------------------
// hcbf_core
// framing state and next-state logic: size line parsing, data and closing
// byte counting, trailer match, error hold and saturating byte total
// ----------------------------------------------------------------------------
module hcbf_core #(
    parameter int MAX_HEX_DIGITS = hcbf_pkg::MAX_HEX_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  hcbf_pkg::in_t                word,
    input  logic [hcbf_pkg::LIMIT_W-1:0] limit,
    output hcbf_pkg::out_t               result
);
    import hcbf_pkg::*;

    localparam int ACC_W = 4 * MAX_HEX_DIGITS;

    localparam logic [2:0] PH_SIZE  = 3'd0;
    localparam logic [2:0] PH_DATA  = 3'd1;
    localparam logic [2:0] PH_CLOSE = 3'd2;
    localparam logic [2:0] PH_TRAIL = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;
    localparam logic [2:0] PH_ERR1  = 3'd5;
    localparam logic [2:0] PH_ERR2  = 3'd6;
    localparam logic [2:0] PH_ERR3  = 3'd7;

    localparam logic [ROLE_W-1:0] ROLE_SIZE  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_DATA  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_CLOSE = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_TRAIL = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_HEX  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        return r;
    endfunction

    logic [2:0]         phase_reg, phase_next;
    logic [LINE_W-1:0]  line_chars_reg, line_chars_next;
    logic               digits_ended_reg, digits_ended_next;
    logic               cr_pending_reg, cr_pending_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [1:0]         trailer_match_reg, trailer_match_next;
    logic               any_chunk_reg, any_chunk_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [2:0]         phase_e;
    logic [LINE_W-1:0]  line_chars_e;
    logic               digits_ended_e;
    logic               cr_pending_e;
    logic [ACC_W-1:0]   acc_e;
    logic [ACC_W-1:0]   bytes_left_e;
    logic [1:0]         trailer_match_e;
    logic               any_chunk_e;
    logic [TOTAL_W-1:0] total_e;

    logic [LIMIT_W-1:0] lim;
    logic [4:0]         hex;
    logic [LINE_W-1:0]  count;
    logic               line_end;
    logic [ACC_W-1:0]   bl_dec;
    logic [BYTE_W-1:0]  want;
    logic [BYTE_W-1:0]  b;
    logic [ROLE_W-1:0]  role;
    logic               done;
    logic [ERR_W-1:0]   err;

    always_comb
    begin
        b = word.in_byte;

        if (word.start_req)
        begin
            phase_e         = PH_SIZE;
            line_chars_e    = '0;
            digits_ended_e  = 1'b0;
            cr_pending_e    = 1'b0;
            acc_e           = '0;
            bytes_left_e    = '0;
            trailer_match_e = 2'd0;
            any_chunk_e     = 1'b0;
            total_e         = '0;
        end
        else
        begin
            phase_e         = phase_reg;
            line_chars_e    = line_chars_reg;
            digits_ended_e  = digits_ended_reg;
            cr_pending_e    = cr_pending_reg;
            acc_e           = acc_reg;
            bytes_left_e    = bytes_left_reg;
            trailer_match_e = trailer_match_reg;
            any_chunk_e     = any_chunk_reg;
            total_e         = total_reg;
        end

        if (limit < LIMIT_MIN) lim = LIMIT_MIN;
        else if (limit > LIMIT_MAX) lim = LIMIT_MAX;
        else lim = limit;

        hex      = hex_decode(b);
        count    = line_chars_e + LINE_W'(1);
        line_end = (b == CHAR_LF) && cr_pending_e;
        bl_dec   = bytes_left_e - ACC_W'(1);
        want     = trailer_match_e[0] ? CHAR_LF : CHAR_CR;

        phase_next         = phase_e;
        line_chars_next    = line_chars_e;
        digits_ended_next  = digits_ended_e;
        cr_pending_next    = cr_pending_e;
        acc_next           = acc_e;
        bytes_left_next    = bytes_left_e;
        trailer_match_next = trailer_match_e;
        any_chunk_next     = any_chunk_e;
        total_next         = total_e;
        role               = ROLE_SIZE;
        done               = 1'b0;

        if (phase_e <= PH_TRAIL && total_e != TOTAL_SAT)
            total_next = total_e + TOTAL_W'(1);

        case (phase_e)
            PH_SIZE:
            begin
                role = ROLE_SIZE;
                if (line_chars_e == '0 && !hex[4])
                begin
                    phase_next = PH_ERR2;
                end
                else
                begin
                    if (!digits_ended_e)
                    begin
                        if (hex[4] && line_chars_e < LINE_W'(MAX_HEX_DIGITS))
                            acc_next = {acc_e[ACC_W-5:0], hex[3:0]};
                        else
                            digits_ended_next = 1'b1;
                    end
                    cr_pending_next = (b == CHAR_CR);
                    line_chars_next = count;
                    if (line_end)
                    begin
                        line_chars_next   = '0;
                        digits_ended_next = 1'b0;
                        cr_pending_next   = 1'b0;
                        acc_next          = '0;
                        if (acc_e == '0)
                        begin
                            if (!any_chunk_e)
                            begin
                                phase_next = PH_ERR3;
                            end
                            else
                            begin
                                phase_next         = PH_TRAIL;
                                trailer_match_next = 2'd2;
                            end
                        end
                        else
                        begin
                            bytes_left_next = acc_e;
                            any_chunk_next  = 1'b1;
                            phase_next      = PH_DATA;
                        end
                    end
                    else if (count >= lim)
                    begin
                        phase_next = PH_ERR1;
                    end
                end
            end
            PH_DATA:
            begin
                role            = ROLE_DATA;
                bytes_left_next = bl_dec;
                if (bl_dec == '0)
                begin
                    bytes_left_next = ACC_W'(2);
                    phase_next      = PH_CLOSE;
                end
            end
            PH_CLOSE:
            begin
                role = ROLE_CLOSE;
                if (bytes_left_e <= ACC_W'(1))
                begin
                    bytes_left_next   = '0;
                    line_chars_next   = '0;
                    digits_ended_next = 1'b0;
                    cr_pending_next   = 1'b0;
                    acc_next          = '0;
                    phase_next        = PH_SIZE;
                end
                else
                begin
                    bytes_left_next = bl_dec;
                end
            end
            PH_TRAIL:
            begin
                role = ROLE_TRAIL;
                if (b == want)
                begin
                    if (trailer_match_e == 2'd3)
                    begin
                        trailer_match_next = 2'd0;
                        done               = 1'b1;
                        phase_next         = PH_DONE;
                    end
                    else
                    begin
                        trailer_match_next = trailer_match_e + 2'd1;
                    end
                end
                else
                begin
                    trailer_match_next = (b == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_DONE:
            begin
                role = ROLE_TRAIL;
            end
            default:
            begin
                role = ROLE_SIZE;
            end
        endcase

        case (phase_next)
            PH_ERR1: err = ERR_TOO_LONG;
            PH_ERR2: err = ERR_NOT_HEX;
            PH_ERR3: err = ERR_EMPTY;
            default: err = ERR_NONE;
        endcase

        result.out_byte     = b;
        result.byte_role    = role;
        result.message_done = done;
        result.error_code   = err;
        result.total_bytes  = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SIZE;
            line_chars_reg    <= '0;
            digits_ended_reg  <= 1'b0;
            cr_pending_reg    <= 1'b0;
            acc_reg           <= '0;
            bytes_left_reg    <= '0;
            trailer_match_reg <= 2'd0;
            any_chunk_reg     <= 1'b0;
            total_reg         <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            line_chars_reg    <= line_chars_next;
            digits_ended_reg  <= digits_ended_next;
            cr_pending_reg    <= cr_pending_next;
            acc_reg           <= acc_next;
            bytes_left_reg    <= bytes_left_next;
            trailer_match_reg <= trailer_match_next;
            any_chunk_reg     <= any_chunk_next;
            total_reg         <= total_next;
        end
    end

endmodule

[design/http_chunked_body_framer_top.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_framer_top
// chunked message body framer: tags every body byte with its role, reports
// done and the byte total, holds errors until a start; apb register port
// ----------------------------------------------------------------------------
// each accepted word's result is registered in the output register, or in the skid while the output stalls
// throughput: one word per cycle while body_stall is low, set by the single-pass state update
// a two-entry output stage (result register plus skid) decouples the sides
// reset: asynchronous, active low; framing state cleared, limit back to 18
// ----------------------------------------------------------------------------
module http_chunked_body_framer_top #(
    parameter int MAX_HEX_DIGITS = hcbf_pkg::MAX_HEX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            body_valid,
    output logic                            body_stall,
    input  hcbf_pkg::in_t                   body_word,
    output logic                            tag_valid,
    input  logic                            tag_stall,
    output hcbf_pkg::out_t                  tag_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hcbf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hcbf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hcbf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hcbf_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               accept;
    out_t               result;
    logic               out_valid_reg;
    out_t               out_data_reg;
    logic               skid_valid_reg;
    out_t               skid_data_reg;
    logic               out_free;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SIZE_LINE_LIMIT)
                  ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && paddr[APB_ADDR_W-1] == 1'b0)
            limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign body_stall = skid_valid_reg;
    assign accept     = body_valid && !skid_valid_reg;
    assign out_free   = !out_valid_reg || !tag_stall;

    hcbf_core #(
        .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (body_word),
        .limit  (limit_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign tag_valid = out_valid_reg;
    assign tag_word  = out_data_reg;

endmodule

[tb/hcbf_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcbf_tb_pkg
// codes and the tag scoreboard for the chunked body framer bench: a framing
// predictor fed by every accepted body word, and an in-order check of tags
// ----------------------------------------------------------------------------
package hcbf_tb_pkg;

    import hcbf_pkg::*;

    localparam logic [ROLE_W-1:0] ROLE_SIZE_LINE = ROLE_W'(0);
    localparam logic [ROLE_W-1:0] ROLE_DATA      = ROLE_W'(1);
    localparam logic [ROLE_W-1:0] ROLE_CLOSING   = ROLE_W'(2);
    localparam logic [ROLE_W-1:0] ROLE_TRAILER   = ROLE_W'(3);

    localparam logic [ERR_W-1:0] ERR_NONE        = ERR_W'(0);
    localparam logic [ERR_W-1:0] ERR_LINE_LONG   = ERR_W'(1);
    localparam logic [ERR_W-1:0] ERR_NOT_HEX     = ERR_W'(2);
    localparam logic [ERR_W-1:0] ERR_EMPTY_FIRST = ERR_W'(3);

    localparam logic [BYTE_W-1:0] CR = 8'h0D;
    localparam logic [BYTE_W-1:0] LF = 8'h0A;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_CLOSE,
        PH_TRAIL,
        PH_DONE,
        PH_ERR_LONG,
        PH_ERR_HEX,
        PH_ERR_EMPTY
    } frame_phase_e;

    function automatic int hex_val(logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    class framer_scoreboard;

        logic [LIMIT_W-1:0] limit_reg;
        frame_phase_e       frame_state;
        int                 line_chars;
        bit                 digits_ended;
        bit                 cr_pending;
        logic [63:0]        size_acc;
        logic [63:0]        bytes_left;
        logic [1:0]         trailer_match;
        bit                 any_chunk;
        logic [TOTAL_W-1:0] total;

        out_t tag_words_due[$];
        int   failures;
        int   words_noted;
        int   words_checked;
        int   messages_done;
        int   error_words;

        function new();
            limit_reg     = LIMIT_RESET;
            failures      = 0;
            words_noted   = 0;
            words_checked = 0;
            messages_done = 0;
            error_words   = 0;
            clear_all();
        endfunction

        function void set_limit(logic [APB_DATA_W-1:0] value);
            limit_reg = value[LIMIT_W-1:0];
        endfunction

        function int pending();
            return tag_words_due.size();
        endfunction

        function void clear_line();
            line_chars   = 0;
            digits_ended = 1'b0;
            cr_pending   = 1'b0;
            size_acc     = '0;
        endfunction

        function void clear_all();
            frame_state   = PH_SIZE;
            clear_line();
            bytes_left    = '0;
            trailer_match = '0;
            any_chunk     = 1'b0;
            total         = '0;
        endfunction

        function void size_line_step(logic [BYTE_W-1:0] b);
            int          lim;
            int          count;
            int          v;
            bit          line_end;
            logic [63:0] chunk_len;
            lim      = limit_reg;
            if (lim < LIMIT_MIN)
                lim = LIMIT_MIN;
            if (lim > LIMIT_MAX)
                lim = LIMIT_MAX;
            count    = line_chars + 1;
            v        = hex_val(b);
            line_end = (b == LF) && cr_pending;
            if (line_chars == 0 && v < 0)
            begin
                frame_state = PH_ERR_HEX;
                return;
            end
            if (!digits_ended)
            begin
                if (v >= 0 && line_chars < MAX_HEX_DIGITS_DEF)
                    size_acc = {size_acc[59:0], 4'(v)};
                else
                    digits_ended = 1'b1;
            end
            cr_pending = (b == CR);
            line_chars = count;
            if (line_end)
            begin
                chunk_len = size_acc;
                clear_line();
                if (chunk_len == 0)
                begin
                    if (!any_chunk)
                        frame_state = PH_ERR_EMPTY;
                    else
                    begin
                        frame_state   = PH_TRAIL;
                        trailer_match = 2'd2;
                    end
                end
                else
                begin
                    bytes_left  = chunk_len;
                    any_chunk   = 1'b1;
                    frame_state = PH_DATA;
                end
                return;
            end
            if (count >= lim)
                frame_state = PH_ERR_LONG;
        endfunction

        function void note_word(in_t w);
            out_t              tag;
            logic [BYTE_W-1:0] b;
            logic [BYTE_W-1:0] want_char;
            b   = w.in_byte;
            tag = '0;
            tag.out_byte = b;
            if (w.start_req)
                clear_all();
            if (frame_state inside {PH_SIZE, PH_DATA, PH_CLOSE, PH_TRAIL} && total != TOTAL_SAT)
                total = total + 1'b1;
            case (frame_state)
                PH_SIZE:
                begin
                    tag.byte_role = ROLE_SIZE_LINE;
                    size_line_step(b);
                end
                PH_DATA:
                begin
                    tag.byte_role = ROLE_DATA;
                    bytes_left    = bytes_left - 1'b1;
                    if (bytes_left == 0)
                    begin
                        bytes_left  = 64'd2;
                        frame_state = PH_CLOSE;
                    end
                end
                PH_CLOSE:
                begin
                    tag.byte_role = ROLE_CLOSING;
                    if (bytes_left > 0)
                        bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0)
                    begin
                        clear_line();
                        frame_state = PH_SIZE;
                    end
                end
                PH_TRAIL:
                begin
                    tag.byte_role = ROLE_TRAILER;
                    want_char     = trailer_match[0] ? LF : CR;
                    if (b == want_char)
                    begin
                        if (trailer_match == 2'd3)
                        begin
                            trailer_match    = '0;
                            tag.message_done = 1'b1;
                            frame_state      = PH_DONE;
                        end
                        else
                            trailer_match = trailer_match + 1'b1;
                    end
                    else
                        trailer_match = (b == CR) ? 2'd1 : 2'd0;
                end
                PH_DONE:
                    tag.byte_role = ROLE_TRAILER;
                default:
                    tag.byte_role = ROLE_SIZE_LINE;
            endcase
            case (frame_state)
                PH_ERR_LONG:  tag.error_code = ERR_LINE_LONG;
                PH_ERR_HEX:   tag.error_code = ERR_NOT_HEX;
                PH_ERR_EMPTY: tag.error_code = ERR_EMPTY_FIRST;
                default:      tag.error_code = ERR_NONE;
            endcase
            tag.total_bytes = total;
            tag_words_due.push_back(tag);
            words_noted++;
        endfunction

        function void check_field(string name, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_word(out_t got);
            out_t want;
            if (tag_words_due.size() == 0)
            begin
                $error("tag word 0x%0h arrived with nothing expected", got);
                failures++;
                return;
            end
            want = tag_words_due.pop_front();
            words_checked++;
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_role", want.byte_role, got.byte_role);
            check_field("message_done", want.message_done, got.message_done);
            check_field("error_code", want.error_code, got.error_code);
            check_field("total_bytes", want.total_bytes, got.total_bytes);
            if (want.message_done)
                messages_done++;
            if (want.error_code != ERR_NONE)
                error_words++;
        endfunction

        function void report_leftovers();
            if (tag_words_due.size() != 0)
            begin
                $error("%0d tag words never arrived", tag_words_due.size());
                failures++;
            end
        endfunction

    endclass

endpackage

[tb/tb_http_chunked_body_framer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_framer_top
// self-checking bench for the chunked body framer: directed framing and error
// cases, then random chunked messages (mostly well formed, some broken or cut
// short) under several line limits and idle mixes, each tag word checked
// in order against a framing predictor
// ----------------------------------------------------------------------------
module tb_http_chunked_body_framer_top;

    import hcbf_pkg::*;
    import hcbf_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  body_valid;
    logic                  body_stall;
    in_t                   body_word;
    logic                  tag_valid;
    logic                  tag_stall;
    out_t                  tag_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    framer_scoreboard sb;
    in_t              body_q[$];
    bit               open_msg;
    int               line_room;
    int               src_idle_pct;
    int               sink_idle_pct;
    int               hold_left;
    bit               long_hold_req = 1'b0;
    int unsigned      cycle_count = 0;

    http_chunked_body_framer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_stall (body_stall),
        .body_word  (body_word),
        .tag_valid  (tag_valid),
        .tag_stall  (tag_stall),
        .tag_word   (tag_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[http_chunked_body_framer_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tag_valid && !tag_stall)
            sb.check_word(tag_word);
    end

    // output side stall, with an occasional long hold-off
    initial
    begin
        tag_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 60;
            end
            if (hold_left > 0)
            begin
                tag_stall <= 1'b1;
                hold_left--;
            end
            else
                tag_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    function automatic void push_body(logic [BYTE_W-1:0] b);
        in_t w;
        w.in_byte   = b;
        w.start_req = open_msg;
        open_msg    = 1'b0;
        body_q.push_back(w);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n);
        if (n < 10)
            return 8'("0" + n);
        return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
    endfunction

    function automatic int pick_chunk_len();
        if (line_room >= 2 && $urandom_range(4) == 0)
            return $urandom_range(16, 48);
        return $urandom_range(1, 12);
    endfunction

    function automatic void push_size_line(logic [31:0] chunk_len, int overrun, bit bad_first);
        logic [BYTE_W-1:0] digs[$];
        logic [31:0]       rest;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] prev;
        int                free;
        int                zeros;
        int                ext_len;
        int                i;
        if (bad_first)
        begin
            do
                c = 8'($urandom_range(255));
            while (hex_val(c) >= 0);
            push_body(c);
        end
        rest = chunk_len;
        do
        begin
            digs.push_front(hex_char(rest[3:0]));
            rest = rest >> 4;
        end
        while (rest != 0);
        free    = line_room - digs.size();
        zeros   = 0;
        ext_len = 0;
        if (overrun > 0)
            zeros = free + overrun;
        else
            case ($urandom_range(3))
                0: zeros = free;
                1: ext_len = free;
                2: zeros = (free > 0) ? $urandom_range(1) : 0;
                default: ;
            endcase
        repeat (zeros)
            push_body("0");
        foreach (digs[j])
            push_body(digs[j]);
        prev = 8'h00;
        for (i = 0; i < ext_len; i++)
        begin
            if (i == 0)
                case ($urandom_range(2))
                    0: c = ";";
                    1: c = LF;
                    default: c = " ";
                endcase
            else
                c = 8'($urandom_range(255));
            if (c == LF && prev == CR)
                c = "=";
            if (c == CR && i == ext_len - 1)
                c = ";";
            push_body(c);
            prev = c;
        end
        push_body(CR);
        push_body(LF);
    endfunction

    // one message: mostly well formed, some with an empty first chunk,
    // a non-hex or overlong size line, or cut short
    function automatic void build_message();
        int          kind;
        int          nchunks;
        int          bad_line;
        int          first_idx;
        int          cut;
        int          i;
        bit          empty_first;
        bit          not_hex;
        bit          too_long;
        logic [31:0] chunk_len;
        kind        = $urandom_range(99);
        empty_first = (kind >= 70 && kind < 78);
        not_hex     = (kind >= 78 && kind < 86);
        too_long    = (kind >= 86 && kind < 92);
        first_idx   = body_q.size();
        open_msg    = 1'b1;
        nchunks     = empty_first ? 0 : $urandom_range(1, 3);
        bad_line    = $urandom_range(0, nchunks);
        for (i = 0; i < nchunks; i++)
        begin
            chunk_len = pick_chunk_len();
            push_size_line(chunk_len, (too_long && bad_line == i) ? $urandom_range(1, 3) : 0,
                           not_hex && bad_line == i);
            repeat (chunk_len)
                push_body(8'($urandom_range(255)));
            if ($urandom_range(7) == 0)
            begin
                push_body(8'($urandom_range(255)));
                push_body(8'($urandom_range(255)));
            end
            else
            begin
                push_body(CR);
                push_body(LF);
            end
        end
        push_size_line(0, (too_long && bad_line == nchunks) ? $urandom_range(1, 3) : 0,
                       not_hex && bad_line == nchunks);
        repeat ($urandom_range(2))
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(3) == 0)
                    push_body($urandom_range(1) ? CR : LF);
                else
                    push_body(8'($urandom_range(255)));
            end
            push_body(CR);
            push_body(LF);
        end
        push_body(CR);
        push_body(LF);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                push_body(8'($urandom_range(255)));
        if (kind >= 92)
        begin
            cut = $urandom_range(1, body_q.size() - first_idx - 1);
            while (body_q.size() > first_idx + cut)
                void'(body_q.pop_back());
        end
    endfunction

    task automatic send_word(input in_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            body_valid <= 1'b0;
            @(posedge clk);
        end
        body_valid <= 1'b1;
        body_word  <= w;
        @(posedge clk);
        while (body_stall)
            @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic send_queued();
        while (body_q.size() > 0)
            send_word(body_q.pop_front());
    endtask

    task automatic drain();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_limit(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_line_limit(input logic [LIMIT_W-1:0] lim);
        int eff;
        apb_write(REG_SIZE_LINE_LIMIT, ($urandom() & 32'hFFFF_FFE0) | APB_DATA_W'(lim));
        eff       = (lim < LIMIT_MIN) ? LIMIT_MIN : (lim > LIMIT_MAX) ? LIMIT_MAX : lim;
        line_room = eff - 2;
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int src_pct, input int sink_pct,
                             input int n_items, input bit long_hold);
        int sent;
        bit hold_asked;
        set_line_limit(lim);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        hold_asked    = 1'b0;
        while (sent < n_items)
        begin
            build_message();
            // the last message of a phase is cut at the word budget
            while (sent + body_q.size() > n_items)
                void'(body_q.pop_back());
            if (long_hold && !hold_asked && sent >= 20)
            begin
                long_hold_req = 1'b1;
                hold_asked    = 1'b1;
            end
            sent += body_q.size();
            send_queued();
        end
        body_valid <= 1'b0;
        drain();
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        body_valid    = 1'b0;
        body_word     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        src_idle_pct  = 23;
        sink_idle_pct = 48;
        line_room     = 16;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_line_limit(5'd18);

        // lone lf in the size line, extreme data bytes, trailer end, byte after done
        open_msg = 1'b1;
        push_body("2"); push_body(LF); push_body(CR); push_body(LF);
        push_body(8'h00); push_body(8'hFF); push_body(CR); push_body(LF);
        push_body("0"); push_body(CR); push_body(LF); push_body(CR); push_body(LF);
        push_body("Z");
        // empty first chunk, then a byte held in error
        open_msg = 1'b1;
        push_body("0"); push_body(CR); push_body(LF); push_body("x");
        // size line not starting with a hex digit
        open_msg = 1'b1;
        push_body("G"); push_body("1");
        // cr not followed by lf inside a size line
        open_msg = 1'b1;
        push_body("1"); push_body(CR); push_body("x");
        send_queued();
        body_valid <= 1'b0;
        drain();

        run_phase(5'd3, 23, 48, 40, 1'b0);
        run_phase(5'd18, 23, 48, 90, 1'b0);
        run_phase(5'd0, 48, 23, 40, 1'b0);
        run_phase(5'd31, 48, 23, 90, 1'b0);
        run_phase(5'd9, 0, 0, 70, 1'b1);
        run_phase(5'($urandom_range(4, 17)), 0, 0, 70, 1'b0);

        sb.report_leftovers();
        $display("covered %0d body words, line limits 3 to 18, three idle mixes, one long hold",
                 sb.words_noted);
        $display("checked %0d tag words: %0d messages completed, %0d words under an error code",
                 sb.words_checked, sb.messages_done, sb.error_words);
        if (sb.failures == 0)
            $display("[http_chunked_body_framer_top] OK");
        else
            $display("[http_chunked_body_framer_top] ERROR");
        $finish;
    end

endmodule
